>>> sv/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg
// Shared widths, command codes and payload types for the running statistics
// block.
// ----------------------------------------------------------------------------
package rmvs_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int COUNT_BITS  = 32;
    localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
    localparam int SUM_BITS    = 64;

    // Square root operand: variance scaled by the fraction, padded to even.
    localparam int ROOT_IN_BITS = ((SUM_BITS + FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_BITS    = ROOT_IN_BITS / 2;

    // Command codes.
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [SAMPLE_BITS-1:0] sample;
    } rmvs_in_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  count;
        logic [MEAN_BITS-1:0]   mean;
        logic [SUM_BITS-1:0]    sample_variance;
        logic [MEAN_BITS-1:0]   std_dev;
        logic [SAMPLE_BITS-1:0] minimum;
        logic [SAMPLE_BITS-1:0] maximum;
        logic [SUM_BITS-1:0]    total;
    } rmvs_out_t;

endpackage

>>> sv/rmvs_div.sv
// ----------------------------------------------------------------------------
// rmvs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmvs_div #(
    parameter int N = 64,
    parameter int D = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  quo_reg, quo_next;
    logic [D:0]    rem_reg, rem_next;
    logic [D-1:0]  dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [D:0]    rem_sh;
    logic [D+1:0]  diff;
    logic          ge;

    // One restoring step: the dividend shifts out of the top of the quotient
    // register while quotient bits shift in at the bottom.
    always_comb begin
        rem_sh    = {rem_reg[D-1:0], quo_reg[N-1]};
        diff      = {1'b0, rem_sh} - {2'b00, dsr_reg};
        ge        = !diff[D+1];
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CW'(N);
            run_next = 1'b1;
        end else if (run_reg) begin
            quo_next = {quo_reg[N-2:0], ge};
            rem_next = ge ? diff[D:0] : rem_sh;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/rmvs_mul.sv
// ----------------------------------------------------------------------------
// rmvs_mul
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rmvs_mul #(
    parameter int W = 40
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] product
);

    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg, acc_next;
    logic [2*W-1:0] a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           run_reg, run_next;
    logic           done_reg, done_next;

    // Add the shifted multiplicand for each set multiplier bit.
    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next = '0;
            a_next   = (2*W)'(a);
            b_next   = b;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[2*W-2:0], 1'b0};
            b_next   = {1'b0, b_reg[W-1:1]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> sv/rmvs_sqrt.sv
// ----------------------------------------------------------------------------
// rmvs_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rmvs_sqrt #(
    parameter int R = 80
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [R-1:0]   radicand,
    output logic           done,
    output logic [R/2-1:0] root
);

    localparam int HW = R / 2;
    localparam int CW = $clog2(HW + 1);

    logic [R-1:0]  rad_reg, rad_next;
    logic [HW:0]   rem_reg, rem_next;
    logic [HW-1:0] root_reg, root_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [HW+2:0] rem_sh;
    logic [HW+2:0] trial;
    logic [HW+3:0] diff;
    logic          ge;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        rem_sh    = {rem_reg, rad_reg[R-1:R-2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = {1'b0, rem_sh} - {1'b0, trial};
        ge        = !diff[HW+3];
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(HW);
            run_next  = 1'b1;
        end else if (run_reg) begin
            rad_next  = {rad_reg[R-3:0], 2'b00};
            rem_next  = ge ? diff[HW:0] : rem_sh[HW:0];
            root_next = {root_reg[HW-2:0], ge};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> sv/running_mean_variance_stats.sv
// Sequence: an add runs a mean divide and a multiply, then, with two or more
// samples, a variance divide and a root before the result loads.
// An unused command with two or more samples runs the variance divide and
// root; start, clear and an unused command with fewer than two samples load directly.
// Throughput: the next input transfer is taken only after the result loads;
// synchronous active-low reset zeroes the sequencer, statistics and flags.
// ----------------------------------------------------------------------------
// running_mean_variance_stats
// Welford running count, mean, variance, standard deviation, min, max and
// total over unsigned samples, using one divider shared by the mean and variance steps, one multiplier and one root.
// ----------------------------------------------------------------------------
module running_mean_variance_stats (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rmvs_pkg::rmvs_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rmvs_pkg::rmvs_out_t m_data
);
    import rmvs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MEAN, ST_MUL, ST_VSEL, ST_VAR, ST_ROOT, ST_OUT
    } state_t;

    localparam int PROD_BITS = 2 * MEAN_BITS;
    localparam int PROD_EXT  = (PROD_BITS > SUM_BITS + FRAC_BITS) ?
                               PROD_BITS : SUM_BITS + FRAC_BITS + 1;
    localparam int ROOT_EXT  = ROOT_BITS + MEAN_BITS;

    state_t                 state_reg, state_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [MEAN_BITS-1:0]   mean_reg, mean_next;
    logic [SUM_BITS-1:0]    sds_reg, sds_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SUM_BITS-1:0]    total_reg, total_next;
    logic [MEAN_BITS-1:0]   xs_reg, xs_next;
    logic                   d1neg_reg, d1neg_next;
    logic [MEAN_BITS-1:0]   d1mag_reg, d1mag_next;
    logic [SUM_BITS-1:0]    var_reg, var_next;
    logic [MEAN_BITS-1:0]   std_reg, std_next;
    logic                   m_valid_reg, m_valid_next;
    rmvs_out_t              out_reg, out_next;

    logic                   div_start_reg, div_start_next;
    logic [SUM_BITS-1:0]    div_num_reg, div_num_next;
    logic [COUNT_BITS-1:0]  div_den_reg, div_den_next;
    logic                   mul_start_reg, mul_start_next;
    logic [MEAN_BITS-1:0]   mul_a_reg, mul_a_next;
    logic [MEAN_BITS-1:0]   mul_b_reg, mul_b_next;
    logic                   sq_start_reg, sq_start_next;

    logic                   div_done, mul_done, sq_done;
    logic [SUM_BITS-1:0]    div_quo;
    logic [PROD_BITS-1:0]   mul_prod;
    logic [ROOT_BITS-1:0]   sq_root;

    logic [MEAN_BITS-1:0]   xs_in;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [MEAN_BITS-1:0]   quo_m;
    logic [MEAN_BITS-1:0]   mean_upd;
    logic [PROD_EXT-1:0]    prod_ext;
    logic [SUM_BITS-1:0]    contrib;
    logic [SUM_BITS:0]      sds_sum;
    logic [ROOT_EXT-1:0]    root_ext;

    // Arithmetic units; the divider is shared by the mean and variance steps.
    rmvs_div #(.N(SUM_BITS), .D(COUNT_BITS)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_num_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    rmvs_mul #(.W(MEAN_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    rmvs_sqrt #(.R(ROOT_IN_BITS)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start_reg),
        .radicand (ROOT_IN_BITS'({var_reg, {FRAC_BITS{1'b0}}})),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // Datapath helpers.
    always_comb begin
        xs_in     = {s_data.sample, {FRAC_BITS{1'b0}}};
        count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
        quo_m     = div_quo[MEAN_BITS-1:0];
        mean_upd  = d1neg_reg ? mean_reg - quo_m : mean_reg + quo_m;
        prod_ext  = PROD_EXT'(mul_prod);
        contrib   = (|(prod_ext >> (SUM_BITS + FRAC_BITS))) ? '1 :
                    prod_ext[SUM_BITS+FRAC_BITS-1:FRAC_BITS];
        sds_sum   = {1'b0, sds_reg} + {1'b0, contrib};
        root_ext  = ROOT_EXT'(sq_root);
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        mean_next      = mean_reg;
        sds_next       = sds_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        total_next     = total_reg;
        xs_next        = xs_reg;
        d1neg_next     = d1neg_reg;
        d1mag_next     = d1mag_reg;
        var_next       = var_reg;
        std_next       = std_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        div_start_next = 1'b0;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        mul_start_next = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        sq_start_next  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_VSEL;
                    case (s_data.cmd)
                        CMD_ADD: begin
                            count_next = count_inc;
                            total_next = total_reg + SUM_BITS'(s_data.sample);
                            if (s_data.sample < min_reg) begin
                                min_next = s_data.sample;
                            end else if (s_data.sample > max_reg) begin
                                max_next = s_data.sample;
                            end
                            xs_next        = xs_in;
                            d1neg_next     = xs_in < mean_reg;
                            d1mag_next     = (xs_in < mean_reg) ? mean_reg - xs_in
                                                                : xs_in - mean_reg;
                            div_num_next   = SUM_BITS'((xs_in < mean_reg) ?
                                                       mean_reg - xs_in : xs_in - mean_reg);
                            div_den_next   = count_inc;
                            div_start_next = 1'b1;
                            state_next     = ST_MEAN;
                        end
                        CMD_START: begin
                            count_next = COUNT_BITS'(1);
                            mean_next  = xs_in;
                            sds_next   = '0;
                            min_next   = s_data.sample;
                            max_next   = s_data.sample;
                            total_next = SUM_BITS'(s_data.sample);
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                            mean_next  = '0;
                            sds_next   = '0;
                            min_next   = '0;
                            max_next   = '0;
                            total_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MEAN: begin
                // Mean moves toward the sample; the second deviation keeps
                // the sign of the first, so the product only ever adds.
                if (div_done) begin
                    mean_next      = mean_upd;
                    mul_a_next     = d1mag_reg;
                    mul_b_next     = d1neg_reg ? mean_upd - xs_reg : xs_reg - mean_upd;
                    mul_start_next = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    sds_next   = sds_sum[SUM_BITS] ? '1 : sds_sum[SUM_BITS-1:0];
                    state_next = ST_VSEL;
                end
            end
            ST_VSEL: begin
                if (count_reg < COUNT_BITS'(2)) begin
                    var_next   = '0;
                    std_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    div_num_next   = sds_reg;
                    div_den_next   = count_reg - COUNT_BITS'(1);
                    div_start_next = 1'b1;
                    state_next     = ST_VAR;
                end
            end
            ST_VAR: begin
                if (div_done) begin
                    var_next      = div_quo;
                    sq_start_next = 1'b1;
                    state_next    = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sq_done) begin
                    std_next   = (|(root_ext >> MEAN_BITS)) ? '1 :
                                 root_ext[MEAN_BITS-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Load the result once the previous transfer has gone.
                if (!m_valid_reg || m_ready) begin
                    out_next.count           = count_reg;
                    out_next.mean            = mean_reg;
                    out_next.sample_variance = var_reg;
                    out_next.std_dev         = std_reg;
                    out_next.minimum         = min_reg;
                    out_next.maximum         = max_reg;
                    out_next.total           = total_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        xs_reg      <= xs_next;
        d1neg_reg   <= d1neg_next;
        d1mag_reg   <= d1mag_next;
        var_reg     <= var_next;
        std_reg     <= std_next;
        out_reg     <= out_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            mean_reg      <= '0;
            sds_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            sq_start_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mean_reg      <= mean_next;
            sds_reg       <= sds_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            total_reg     <= total_next;
            m_valid_reg   <= m_valid_next;
            div_start_reg <= div_start_next;
            mul_start_reg <= mul_start_next;
            sq_start_reg  <= sq_start_next;
        end
    end

    // The block takes no second item in the cycle after a transfer.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // Variance is zero below two samples.
    a_var_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.count < COUNT_BITS'(2)) |-> m_data.sample_variance == '0)
        else $error("nonzero variance with fewer than two samples");

    // An empty run reports all-zero statistics.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.count == '0) |->
        (m_data.mean == '0) && (m_data.minimum == '0) && (m_data.maximum == '0)
        && (m_data.total == '0) && (m_data.std_dev == '0))
        else $error("empty statistics are not zero");

endmodule

>>> tb/sv/running_mean_variance_stats_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_variance_stats_tb
// Drives start, add, clear and unused commands into the running statistics block and
// checks every result against a cycle-free model of the Welford update, the
// variance divide and the truncated square root.
// ----------------------------------------------------------------------------
module running_mean_variance_stats_tb;
    import rmvs_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [63:0] SUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [MEAN_BITS-1:0] MEAN_LIMIT = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    rmvs_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rmvs_out_t m_data;

    running_mean_variance_stats dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Statistics held by the checker's own copy of the block.
    logic [COUNT_BITS-1:0]  stat_count;
    logic [MEAN_BITS-1:0]   stat_mean;
    logic [63:0]            stat_sqdev;
    logic [SAMPLE_BITS-1:0] stat_min, stat_max;
    logic [63:0]            stat_total;

    rmvs_out_t stats_expected[$];
    int        fail_count = 0;
    bit        sender_idles = 1'b1;
    bit        sink_idles = 1'b1;

    // Floor of the square root of a wide value, bit by bit.
    function automatic logic [MEAN_BITS-1:0] isqrt(logic [127:0] v);
        logic [127:0] root;
        logic [127:0] trial;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        if (root > 128'(MEAN_LIMIT)) root = 128'(MEAN_LIMIT);
        return root[MEAN_BITS-1:0];
    endfunction

    // Applies one command and returns the statistics reported after it.
    function automatic rmvs_out_t update_stats(rmvs_in_t item);
        rmvs_out_t r;
        logic signed [65:0] xs, old_m, new_m, d1, d2, diff;
        logic [127:0] prod;
        logic [63:0] contrib, var_now;
        logic [64:0] wsum;
        case (item.cmd)
            CMD_ADD: begin
                if (stat_count != COUNT_LIMIT) stat_count = stat_count + COUNT_BITS'(1);
                xs = $signed({26'd0, item.sample, 16'd0});
                old_m = $signed({26'd0, stat_mean});
                diff = xs - old_m;
                // Signed divide truncates toward zero.
                new_m = old_m + diff / $signed({34'd0, stat_count});
                if (new_m < 0) new_m = '0;
                if (new_m > $signed({26'd0, MEAN_LIMIT})) new_m = {26'd0, MEAN_LIMIT};
                stat_mean = new_m[MEAN_BITS-1:0];
                d1 = xs - old_m;
                d2 = xs - new_m;
                prod = 128'(d1 < 0 ? -d1 : d1) * 128'(d2 < 0 ? -d2 : d2);
                prod = prod >> FRAC_BITS;
                contrib = (prod[127:64] != 0) ? SUM_MAX : prod[63:0];
                if (contrib != 0 && ((d1 < 0) != (d2 < 0)))
                    stat_sqdev = (stat_sqdev > contrib) ? stat_sqdev - contrib : 64'd0;
                else begin
                    wsum = {1'b0, stat_sqdev} + {1'b0, contrib};
                    stat_sqdev = wsum[64] ? SUM_MAX : wsum[63:0];
                end
                if (item.sample < stat_min) stat_min = item.sample;
                else if (item.sample > stat_max) stat_max = item.sample;
                stat_total = stat_total + 64'(item.sample);
            end
            CMD_START: begin
                stat_count = COUNT_BITS'(1);
                stat_mean = {item.sample, 16'd0};
                stat_sqdev = '0;
                stat_min = item.sample;
                stat_max = item.sample;
                stat_total = 64'(item.sample);
            end
            CMD_CLEAR: begin
                stat_count = '0; stat_mean = '0; stat_sqdev = '0;
                stat_min = '0; stat_max = '0; stat_total = '0;
            end
            default: ;
        endcase
        var_now = (stat_count < 2) ? 64'd0 : stat_sqdev / 64'(stat_count - 1);
        r.count = stat_count;
        r.mean = stat_mean;
        r.sample_variance = var_now;
        r.std_dev = isqrt({48'd0, var_now, 16'd0});
        r.minimum = stat_min;
        r.maximum = stat_max;
        r.total = stat_total;
        return r;
    endfunction

    // Sends one item, idling for a random burst first now and then. The
    // block is never ready in the cycle after a transfer, so the first wait
    // costs nothing.
    task automatic send_item(logic [1:0] cmd, logic [SAMPLE_BITS-1:0] sample);
        rmvs_in_t item;
        item.cmd = cmd;
        item.sample = sample;
        @(posedge aclk);
        if (sender_idles && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        stats_expected.push_back(update_stats(item));
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (stats_expected.size() != 0) @(posedge aclk);
    endtask

    // Field-by-field check of each result transfer.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (stats_expected.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                fail_count++;
            end else begin
                rmvs_out_t e;
                e = stats_expected.pop_front();
                if (m_data.count != e.count)
                    $display("%0t: count exp %0d got %0d", $time, e.count, m_data.count);
                if (m_data.mean != e.mean)
                    $display("%0t: mean exp %h got %h", $time, e.mean, m_data.mean);
                if (m_data.sample_variance != e.sample_variance)
                    $display("%0t: variance exp %h got %h", $time,
                             e.sample_variance, m_data.sample_variance);
                if (m_data.std_dev != e.std_dev)
                    $display("%0t: std_dev exp %h got %h", $time, e.std_dev, m_data.std_dev);
                if (m_data.minimum != e.minimum)
                    $display("%0t: minimum exp %h got %h", $time, e.minimum, m_data.minimum);
                if (m_data.maximum != e.maximum)
                    $display("%0t: maximum exp %h got %h", $time, e.maximum, m_data.maximum);
                if (m_data.total != e.total)
                    $display("%0t: total exp %h got %h", $time, e.total, m_data.total);
                if (m_data != e) fail_count++;
            end
        end
    end

    // Result side stalls in random bursts while sink idling is on.
    always begin
        @(posedge aclk);
        if (sink_idles && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        m_ready <= 1'b1;
    end

    // Extremes of the sample, every command and the clear-then-add case.
    task automatic test_directed();
        send_item(CMD_ADD, 24'd5);
        send_item(CMD_ADD, 24'd0);
        send_item(CMD_START, 24'hFFFFFF);
        send_item(CMD_ADD, 24'd0);
        send_item(CMD_ADD, 24'hFFFFFF);
        send_item(CMD_ADD, 24'h800000);
        send_item(CMD_UNUSED, 24'h123456);
        send_item(CMD_CLEAR, 24'hFFFFFF);
        send_item(CMD_UNUSED, 24'd0);
        send_item(CMD_ADD, 24'd0);
        send_item(CMD_ADD, 24'hFFFFFF);
        send_item(CMD_ADD, 24'd1);
        send_item(CMD_START, 24'd0);
        send_item(CMD_ADD, 24'd0);
        send_item(CMD_ADD, 24'd1);
        send_item(CMD_START, 24'd100);
        send_item(CMD_ADD, 24'd99);
        send_item(CMD_ADD, 24'd101);
        send_item(CMD_ADD, 24'd100);
    endtask

    // Long runs of adds with random content; now and then start, clear or an unused command.
    task automatic test_random_runs(int n);
        int pick;
        logic [SAMPLE_BITS-1:0] s;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: s = SAMPLE_BITS'($urandom);
                1: s = SAMPLE_BITS'($urandom_range(0, 255));
                2: s = 24'hFFFFFF - SAMPLE_BITS'($urandom_range(0, 255));
                default: s = 24'h400000 + SAMPLE_BITS'($urandom_range(0, 4095));
            endcase
            if (pick < 85) send_item(CMD_ADD, s);
            else if (pick < 93) send_item(CMD_START, s);
            else if (pick < 97) send_item(CMD_CLEAR, s);
            else send_item(CMD_UNUSED, s);
        end
    endtask

    // Sender holds off until every result is back, then goes on.
    task automatic test_drain_pause();
        send_item(CMD_START, SAMPLE_BITS'($urandom));
        send_item(CMD_ADD, SAMPLE_BITS'($urandom));
        wait_drained();
        send_item(CMD_ADD, SAMPLE_BITS'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        stat_count = '0; stat_mean = '0; stat_sqdev = '0;
        stat_min = '0; stat_max = '0; stat_total = '0;
        @(posedge aclk);
        test_directed();
        test_random_runs(900);
        test_drain_pause();
        sender_idles = 1'b0;
        sink_idles = 1'b0;
        test_random_runs(300);
        wait_drained();
        repeat (300) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Time limit for roughly 1220 items plus idling and stalls.
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
sv/rmvs_pkg.sv
sv/rmvs_div.sv
sv/rmvs_mul.sv
sv/rmvs_sqrt.sv
sv/running_mean_variance_stats.sv
tb/sv/running_mean_variance_stats_tb.sv
